FILE: hw/rtl/bmff_pkg.sv
// Shared types and constants for the bar meter with falloff and fade trail.
// Used by bmff_cell and by the top level bar_meter_falloff_fade.
package bmff_pkg;

    // Sizes
    localparam int BAND_COUNT  = 256;
    localparam int MAX_ROWS    = 256;
    localparam int FADE_STEPS  = 90;

    // Field widths
    localparam int BAND_W      = 8;
    localparam int ROW_IDX_IN_W = 8;
    localparam int LEVEL_W     = 16;
    localparam int ROWS_W      = 9;
    localparam int FALL_W      = 16;
    localparam int FRAC_W      = 8;
    localparam int HGT_W       = ROWS_W + FRAC_W;
    localparam int FLVL_W      = 7;
    localparam int CFG_W       = 16;

    // Derived index widths
    localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
    localparam int BAND_IDX_W  = $clog2(BAND_COUNT);

    // Stream word widths
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 40;

    // Input mode codes
    localparam logic MODE_THRESH = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_FALL_STEP = 1'b1;

    // Reset values of the configuration registers
    localparam logic [ROWS_W-1:0] ROW_COUNT_RST = ROWS_W'(16);
    localparam logic [FALL_W-1:0] FALL_STEP_RST = FALL_W'(282);

    // Search token walking down the threshold chain
    typedef struct packed {
        logic                 active;
        logic                 found;
        logic [ROW_IDX_W-1:0] row;
    } srch_t;

    // Per-band state word kept in the band RAM
    typedef struct packed {
        logic [HGT_W-1:0]  height;
        logic [ROWS_W-1:0] trail_row;
        logic [FLVL_W-1:0] fade_level;
    } band_state_t;

    localparam int BAND_STATE_W = $bits(band_state_t);

endpackage

FILE: hw/rtl/bmff_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/bmff_cell.sv
// One threshold cell: holds one threshold entry and passes the search token on.
// Depends on bmff_pkg.
module bmff_cell
    import bmff_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ROW_IDX_W-1:0] cell_idx,
    input  logic                 wr_en,
    input  logic [ROW_IDX_W-1:0] wr_idx,
    input  logic [LEVEL_W-1:0]   wr_data,
    input  logic [LEVEL_W-1:0]   level,
    input  logic [ROWS_W-1:0]    rows_eff,
    input  srch_t                srch_in,
    output srch_t                srch_out
);

    logic [LEVEL_W-1:0] thr_reg;
    logic               active_reg;
    logic               found_reg;
    logic [ROW_IDX_W-1:0] row_reg;
    logic               hit;

    // Load the threshold entry owned by this cell
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == cell_idx))
        begin
            thr_reg <= wr_data;
        end
    end

    // First row in use whose threshold the level reaches
    assign hit = srch_in.active && !srch_in.found
              && ({1'b0, cell_idx} < rows_eff) && (level >= thr_reg);

    // Advance the token one cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= srch_in.active;
        end
    end

    // Carry the match along with the token
    always_ff @(posedge clk)
    begin
        found_reg <= srch_in.found | hit;
        row_reg   <= hit ? cell_idx : srch_in.row;
    end

    assign srch_out = '{active: active_reg, found: found_reg, row: row_reg};

endmodule

FILE: hw/rtl/bar_meter_falloff_fade.sv
// Top level of the bar meter with falloff and fade trail.
// Depends on bmff_pkg, bmff_cell and bmff_ram.
//
// A word with tuser = 0 loads one threshold entry; it gives no result.
// A word with tuser = 1 updates one band: the search token walks the chain
// of MAX_ROWS threshold cells one cell a cycle, then the bar height is
// registered and the fade trail settled; the fade stage waits until the
// output register is free. Updates are handled one at a time; the result
// waits in an output register while the next word is taken. Per-band state
// sits in one RAM with a flip-flop valid bit per band, so no clearing pass
// follows reset. Threshold entries read before being written give an
// undefined row.
module bar_meter_falloff_fade
    import bmff_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: band_index[7:0], row_index[15:8], level[31:16]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: mode
    input  logic                  s_tuser,
    // m_tdata: band_out[7:0], bar_row[16:8], trail_row_out[25:17],
    //          fade_color_index[32:26], zero[39:33]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FADE   = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [ROWS_W-1:0]   row_count_reg;
    logic [FALL_W-1:0]   fall_step_reg;
    logic [ROWS_W-1:0]   rows_eff;

    logic [BAND_W-1:0]   in_band;
    logic [ROW_IDX_IN_W-1:0] in_row;
    logic [LEVEL_W-1:0]  in_level;
    logic                accept;
    logic                thr_wr;
    logic                upd_start;

    logic                start_reg;
    logic [BAND_W-1:0]   band_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                vld_hit_reg;
    logic [BAND_COUNT-1:0] band_vld_reg;

    srch_t               chain [MAX_ROWS+1];
    srch_t               tail;

    logic [BAND_STATE_W-1:0] ram_rdata;
    band_state_t         cur;
    band_state_t         wr_state;
    logic                ram_we;

    logic [ROWS_W-1:0]   y_srch;
    logic [HGT_W-1:0]    y_shift;
    logic [HGT_W:0]      h_sum;
    logic [HGT_W-1:0]    limit;
    logic [HGT_W-1:0]    h_calc;
    logic [ROWS_W-1:0]   y_calc;
    logic [HGT_W-1:0]    h_reg;
    logic [ROWS_W-1:0]   y_reg;

    logic [ROWS_W-1:0]   fr_mid;
    logic [FLVL_W-1:0]   fl_mid;
    logic [ROWS_W-1:0]   fr_new;
    logic [FLVL_W-1:0]   fl_new;

    logic                out_free;
    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Unpack the input word
    assign in_band  = s_tdata[7:0];
    assign in_row   = s_tdata[15:8];
    assign in_level = s_tdata[31:16];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign thr_wr    = accept && (s_tuser == MODE_THRESH)
                    && (32'(in_row) < MAX_ROWS);
    assign upd_start = accept && (s_tuser == MODE_UPDATE)
                    && (32'(in_band) < BAND_COUNT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            fall_step_reg <= FALL_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data[ROWS_W-1:0];
                CFG_FALL_STEP: fall_step_reg <= cfg_data[FALL_W-1:0];
                default: ;
            endcase
        end
    end

    assign rows_eff = (32'(row_count_reg) > MAX_ROWS) ? ROWS_W'(MAX_ROWS)
                                                       : row_count_reg;

    // Hold the band and level of the update under way
    always_ff @(posedge clk)
    begin
        if (upd_start)
        begin
            band_reg    <= in_band;
            level_reg   <= in_level;
            vld_hit_reg <= band_vld_reg[in_band[BAND_IDX_W-1:0]];
        end
    end

    // Launch the search token in the cycle after the word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= upd_start;
        end
    end

    // Threshold chain
    assign chain[0] = '{active: start_reg, found: 1'b0, row: '0};

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        bmff_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (ROW_IDX_W'(i)),
            .wr_en    (thr_wr),
            .wr_idx   (in_row[ROW_IDX_W-1:0]),
            .wr_data  (in_level),
            .level    (level_reg),
            .rows_eff (rows_eff),
            .srch_in  (chain[i]),
            .srch_out (chain[i+1])
        );
    end

    assign tail = chain[MAX_ROWS];

    // Per-band state
    bmff_ram #(
        .WIDTH (BAND_STATE_W),
        .DEPTH (BAND_COUNT)
    ) u_band_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (band_reg[BAND_IDX_W-1:0]),
        .wdata (wr_state),
        .re    (upd_start),
        .raddr (in_band[BAND_IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // A band never written reads as zero
    assign cur = vld_hit_reg ? band_state_t'(ram_rdata) : '0;

    // Bar height: rise at once, else fall by the step and saturate
    always_comb
    begin
        y_srch  = tail.found ? ROWS_W'(tail.row) : rows_eff;
        y_shift = {y_srch, {FRAC_W{1'b0}}};
        limit   = {rows_eff, {FRAC_W{1'b0}}};
        h_sum   = {1'b0, cur.height} + (HGT_W+1)'(fall_step_reg);
        if (y_shift <= cur.height)
        begin
            h_calc = y_shift;
            y_calc = y_srch;
        end
        else
        begin
            h_calc = (h_sum > {1'b0, limit}) ? limit : h_sum[HGT_W-1:0];
            y_calc = h_calc[HGT_W-1:FRAC_W];
        end
        if (y_calc > rows_eff)
        begin
            y_calc = rows_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEARCH && tail.active)
        begin
            h_reg <= h_calc;
            y_reg <= y_calc;
        end
    end

    // Fade trail: restart when the bar reaches it, else count down; once spent, move it to the empty row
    always_comb
    begin
        if (y_reg <= cur.trail_row)
        begin
            fr_mid = y_reg;
            fl_mid = FLVL_W'(FADE_STEPS);
        end
        else
        begin
            fr_mid = cur.trail_row;
            fl_mid = cur.fade_level;
        end
        if (fl_mid == '0)
        begin
            fr_new = rows_eff;
            fl_new = '0;
        end
        else
        begin
            fr_new = fr_mid;
            fl_new = fl_mid - FLVL_W'(1);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign ram_we   = (state_reg == ST_FADE) && out_free;
    assign wr_state = '{height: h_reg, trail_row: fr_new, fade_level: fl_new};

    // Mark bands that hold written state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_vld_reg <= '0;
        end
        else if (ram_we)
        begin
            band_vld_reg[band_reg[BAND_IDX_W-1:0]] <= 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (upd_start)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tail.active)
                begin
                    state_next = ST_FADE;
                end
            end
            ST_FADE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ram_we)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            m_tdata_reg <= {(OUT_DATA_W-BAND_W-2*ROWS_W-FLVL_W)'(0),
                            fl_new, fr_new, y_reg, band_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // A result appears only out of the fade stage
    a_out_from_fade: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FADE))
        else $error("result raised outside the fade stage");

    // The token leaves the chain only while a search is under way
    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> (state_reg == ST_SEARCH))
        else $error("search token out of the chain while not searching");

    // The fade palette index stays below the trail length
    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32:26] < FLVL_W'(FADE_STEPS)))
        else $error("fade color index out of range");

    // No new word is taken while a search runs
    a_busy_search: assert property (@(posedge clk) disable iff (!rst_n)
        (start_reg || tail.active) |-> !s_tready)
        else $error("input taken during a search");
`endif

endmodule

FILE: bench/bar_meter_falloff_fade_test.sv
// Self-checking testbench for bar_meter_falloff_fade: threshold words and band
// updates in, bar and fade results out, checked by an in-bench predictor.
// Depends on bmff_pkg and the bar_meter_falloff_fade RTL.
`timescale 1ns / 1ps

module bar_meter_falloff_fade_test;
    import bmff_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int IDLE_PCT     = 23;

    // One result word, in field order
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [ROWS_W-1:0] bar_row;
        logic [ROWS_W-1:0] trail_row;
        logic [FLVL_W-1:0] shade;
    } bar_res_t;

    // One directed stimulus row; typed rows carry their own expected result
    typedef struct packed {
        logic                    mode;
        logic [BAND_W-1:0]       band;
        logic [ROW_IDX_IN_W-1:0] ridx;
        logic [LEVEL_W-1:0]      level;
        logic                    typed;
        bar_res_t                want;
    } dir_row_t;

    localparam int DIR_ROWS = 20;
    localparam int DIR_IDX_W = $clog2(DIR_ROWS);
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{MODE_UPDATE, 8'h00, 8'h00, 16'hFFFF, 1'b1, '{8'h00, 9'd0, 9'd0, 7'd89}},
        '{MODE_UPDATE, 8'hFF, 8'h00, 16'h0000, 1'b1, '{8'hFF, 9'd1, 9'd16, 7'd0}},
        '{MODE_UPDATE, 8'h00, 8'hFF, 16'h0000, 1'b0, '0},
        '{MODE_UPDATE, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
        '{MODE_UPDATE, 8'h00, 8'h00, 16'hFAFA, 1'b0, '0},
        '{MODE_UPDATE, 8'h00, 8'h00, 16'hFAF9, 1'b0, '0},
        '{MODE_THRESH, 8'hFF, 8'h00, 16'h0000, 1'b0, '0},
        '{MODE_UPDATE, 8'h07, 8'h00, 16'h0000, 1'b1, '{8'h07, 9'd0, 9'd0, 7'd89}},
        '{MODE_THRESH, 8'hFF, 8'h00, 16'hFFFF, 1'b0, '0},
        '{MODE_THRESH, 8'h00, 8'hFF, 16'h5555, 1'b0, '0},
        '{MODE_THRESH, 8'h55, 8'hAA, 16'hAAAA, 1'b0, '0},
        '{MODE_UPDATE, 8'h01, 8'h00, 16'hFFFF, 1'b1, '{8'h01, 9'd0, 9'd0, 7'd89}},
        '{MODE_UPDATE, 8'hAA, 8'h55, 16'hAAAA, 1'b0, '0},
        '{MODE_UPDATE, 8'h55, 8'hAA, 16'h5555, 1'b0, '0},
        '{MODE_UPDATE, 8'h80, 8'h00, 16'h8000, 1'b0, '0},
        '{MODE_UPDATE, 8'h01, 8'h00, 16'h0000, 1'b0, '0},
        '{MODE_UPDATE, 8'h01, 8'h00, 16'h8000, 1'b0, '0},
        '{MODE_UPDATE, 8'hFF, 8'h00, 16'hFFFF, 1'b0, '0},
        '{MODE_THRESH, 8'h00, 8'h55, 16'h7FFF, 1'b0, '0},
        '{MODE_UPDATE, 8'h00, 8'h00, 16'h0001, 1'b0, '0}
    };

    localparam logic [BAND_W-1:0] FOCUS_BANDS [4] = '{8'h00, 8'h3C, 8'hC3, 8'hFF};

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    // Predictor copy of registers and per-band state
    logic [ROWS_W-1:0]  row_count_q;
    logic [FALL_W-1:0]  fall_step_q;
    logic [LEVEL_W-1:0] thr_table     [MAX_ROWS];
    logic [HGT_W-1:0]   height_mem    [BAND_COUNT];
    logic [ROWS_W-1:0]  trail_row_mem [BAND_COUNT];
    logic [FLVL_W-1:0]  trail_life    [BAND_COUNT];

    bar_res_t bars_due [$];
    int       mismatch_count;
    int       cycle_count;
    bit       steady;
    int       hold_requests;
    int       holds_done;
    int       hold_left;

    bar_meter_falloff_fade DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Quantize one level, move the band's falling height and fade trail
    function automatic bar_res_t bar_update(input logic [BAND_W-1:0] band,
                                            input logic [LEVEL_W-1:0] level);
        int unsigned rows;
        int unsigned y;
        int unsigned h;
        int unsigned lim;
        int unsigned fl;
        int unsigned k;
        bit          hit;
        bar_res_t    r;
        rows = (32'(row_count_q) > MAX_ROWS) ? MAX_ROWS : 32'(row_count_q);
        y    = rows;
        hit  = 1'b0;
        // first row whose threshold the level reaches
        for (k = 0; k < rows; k++)
        begin
            if (!hit && level >= thr_table[ROW_IDX_W'(k)])
            begin
                y   = k;
                hit = 1'b1;
            end
        end
        // take a taller bar at once, else fall and saturate at the empty row
        lim = rows << FRAC_W;
        h   = 32'(height_mem[band]);
        if ((y << FRAC_W) <= h)
            h = y << FRAC_W;
        else
        begin
            h = h + 32'(fall_step_q);
            if (h > lim)
                h = lim;
            y = h >> FRAC_W;
        end
        height_mem[band] = HGT_W'(h);
        if (y > rows)
            y = rows;
        // restart the trail when the bar reaches it, else count it down
        if (y <= 32'(trail_row_mem[band]))
        begin
            trail_row_mem[band] = ROWS_W'(y);
            trail_life[band]    = FLVL_W'(FADE_STEPS);
        end
        fl = 32'(trail_life[band]);
        if (fl == 0)
            trail_row_mem[band] = ROWS_W'(rows);
        else
        begin
            fl = fl - 1;
            trail_life[band] = FLVL_W'(fl);
        end
        r.band      = band;
        r.bar_row   = ROWS_W'(y);
        r.trail_row = trail_row_mem[band];
        r.shade     = FLVL_W'(fl);
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        logic [LEVEL_W-1:0] v;
        case ($urandom_range(3))
            0: v = '0;
            1: v = thr_table[ROW_IDX_W'($urandom_range(MAX_ROWS - 1))]
                   + LEVEL_W'($urandom_range(2)) - LEVEL_W'(1);
            2: v = LEVEL_W'($urandom);
            default: v = 16'hFFFF >> $urandom_range(15);
        endcase
        return v;
    endfunction

    // Hold the input stream idle for a random number of cycles
    task automatic idle_gap();
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer one word, wait for the handshake, then predict its result
    task automatic send_word(input logic mode, input logic [BAND_W-1:0] band,
                             input logic [ROW_IDX_IN_W-1:0] ridx,
                             input logic [LEVEL_W-1:0] level,
                             input logic typed, input bar_res_t typed_res);
        bar_res_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {level, ridx, band};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (mode == MODE_THRESH)
            thr_table[ridx] = level;
        else
        begin
            r = bar_update(band, level);
            bars_due.push_back(typed ? typed_res : r);
        end
    endtask

    // Drain the block, let any threshold word settle, then write both registers
    task automatic set_meter(input logic [ROWS_W-1:0] rows_val,
                             input logic [FALL_W-1:0] fall_val);
        s_tvalid <= 1'b0;
        while (bars_due.size() != 0)
            @(posedge clk);
        repeat (MAX_ROWS + 8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROW_COUNT;
        cfg_data  <= CFG_W'(rows_val);
        @(posedge clk);
        row_count_q = rows_val;
        cfg_index <= CFG_FALL_STEP;
        cfg_data  <= fall_val;
        @(posedge clk);
        fall_step_q = fall_val;
        cfg_we <= 1'b0;
    endtask

    // Mostly peak-then-decay bursts on one band, with stray words in between
    task automatic mix_traffic(input int count);
        int                sent;
        int                len;
        int                j;
        logic [BAND_W-1:0] band;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 30)
            begin
                idle_gap();
                send_word(1'($urandom_range(1)), BAND_W'($urandom), ROW_IDX_IN_W'($urandom),
                          pick_level(), 1'b0, '0);
                sent++;
            end
            else
            begin
                band = ($urandom_range(1) == 1) ? FOCUS_BANDS[2'($urandom_range(3))]
                                                : BAND_W'($urandom);
                len  = $urandom_range(1, 130);
                for (j = 0; j < len && sent < count; j++)
                begin
                    idle_gap();
                    if ($urandom_range(99) < 8)
                        send_word(MODE_THRESH, band, ROW_IDX_IN_W'($urandom), pick_level(),
                                  1'b0, '0);
                    else if (j == 0 || $urandom_range(99) < 15)
                        send_word(MODE_UPDATE, band, ROW_IDX_IN_W'($urandom), pick_level(),
                                  1'b0, '0);
                    else
                        send_word(MODE_UPDATE, band, ROW_IDX_IN_W'($urandom),
                                  LEVEL_W'($urandom_range(3)), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Compare each result word with the oldest prediction; drive tready
    always @(posedge clk)
    begin : result_check
        bar_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bars_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result word with none expected, got %h", $time, m_tdata);
            end
            else
            begin
                want = bars_due.pop_front();
                check_field("band_out", 32'(want.band), 32'(m_tdata[7:0]));
                check_field("bar_row", 32'(want.bar_row), 32'(m_tdata[16:8]));
                check_field("trail_row_out", 32'(want.trail_row), 32'(m_tdata[25:17]));
                check_field("fade_color_index", 32'(want.shade), 32'(m_tdata[32:26]));
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (holds_done != hold_requests)
        begin
            holds_done <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int       i;
        dir_row_t drow;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = MODE_THRESH;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ROW_COUNT;
        cfg_data       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        steady         = 1'b0;
        hold_requests  = 0;
        holds_done     = 0;
        hold_left      = 0;
        row_count_q    = ROW_COUNT_RST;
        fall_step_q    = FALL_STEP_RST;
        for (i = 0; i < BAND_COUNT; i++)
        begin
            height_mem[BAND_IDX_W'(i)]    = '0;
            trail_row_mem[BAND_IDX_W'(i)] = '0;
            trail_life[BAND_IDX_W'(i)]    = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole threshold table, descending from full scale to zero
        for (i = 0; i < MAX_ROWS; i++)
        begin
            idle_gap();
            send_word(MODE_THRESH, '0, ROW_IDX_IN_W'(i), LEVEL_W'(65535 - i * 257), 1'b0, '0);
        end

        // Directed rows at the reset settings
        for (i = 0; i < DIR_ROWS; i++)
        begin
            idle_gap();
            drow = DIRECTED_ROWS[DIR_IDX_W'(i)];
            send_word(drow.mode, drow.band, drow.ridx, drow.level, drow.typed, drow.want);
        end

        mix_traffic(180);
        set_meter(9'd256, 16'd0);
        mix_traffic(200);
        set_meter(9'd3, 16'hFFFF);
        mix_traffic(200);
        set_meter(9'd0, 16'd1);
        mix_traffic(60);
        set_meter(9'd1, 16'd255);
        mix_traffic(60);
        set_meter(9'd2, 16'd256);
        mix_traffic(60);
        set_meter(9'd511, FALL_W'($urandom_range(1, 600)));
        mix_traffic(200);

        // No idling, and a long receiver hold-off to back up the block
        set_meter(ROWS_W'($urandom_range(3, 256)), FALL_W'($urandom));
        steady = 1'b1;
        hold_requests++;
        mix_traffic(200);
        steady = 1'b0;

        set_meter(ROWS_W'($urandom_range(3, 256)), FALL_W'($urandom));
        mix_traffic(80);
        set_meter(9'd256, 16'd1);
        mix_traffic(80);

        // Drain and let the last word settle
        s_tvalid <= 1'b0;
        while (bars_due.size() != 0)
            @(posedge clk);
        repeat (MAX_ROWS + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
